### sv/fsd_pkg.sv
// Shared types and constants for the Floyd-Steinberg RGB dither unit.
package fsd_pkg;

    // Line store geometry
    localparam int MaxWidth = 2048;
    localparam int ColW     = $clog2(MaxWidth);
    localparam int WCntW    = ColW + 1;

    // Register widths
    localparam int LineWidthW = 12;
    localparam int ThreshW    = 8;
    localparam int FloorW     = 9;
    localparam int CfgDataW   = 12;
    localparam int CfgIdxW    = 2;
    localparam int CmpW       = (LineWidthW > WCntW) ? LineWidthW : WCntW;

    // Channel and error widths
    localparam int PixW     = 8;
    localparam int NumLanes = 3;
    localparam int ErrW     = 10;
    localparam int StoreW   = NumLanes * ErrW;
    localparam int DataW    = NumLanes * PixW;

    // Register reset values
    localparam logic [LineWidthW-1:0] LineWidthRst = 12'd640;
    localparam logic [ThreshW-1:0]    ThreshRst    = 8'd128;
    localparam logic [FloorW-1:0]     FloorRst     = 9'h1E2;  // -30

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_LINE_WIDTH  = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_ERROR_FLOOR = 2'd2
    } fsd_reg_idx_t;

    // Per-pixel control shared by all channel lanes
    typedef struct packed {
        logic                     en;
        logic                     frame;
        logic                     last;
        logic [ThreshW-1:0]       threshold;
        logic signed [FloorW-1:0] err_floor;
    } fsd_lane_ctl_t;

    // What one lane hands back for a pixel
    typedef struct packed {
        logic                   q;
        logic signed [ErrW-1:0] left_sum;
        logic signed [ErrW-1:0] merged;
    } fsd_lane_res_t;

endpackage

### sv/fsd_line_store.sv
// Row error line store: one write port, one registered read port.
module fsd_line_store (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [fsd_pkg::ColW-1:0]    wr_addr,
    input  logic [fsd_pkg::StoreW-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [fsd_pkg::ColW-1:0]    rd_addr,
    output logic [fsd_pkg::StoreW-1:0]  rd_data
);
    import fsd_pkg::*;

    logic [StoreW-1:0] mem [MaxWidth];

    // Write next-row errors
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read old contents, hold when idle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/fsd_lane.sv
// One channel lane: threshold, error floor and Floyd-Steinberg shares.
module fsd_lane (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fsd_pkg::fsd_lane_ctl_t            ctl,
    input  logic [fsd_pkg::PixW-1:0]          orig,
    input  logic signed [fsd_pkg::ErrW-1:0]   above,
    output fsd_pkg::fsd_lane_res_t            res
);
    import fsd_pkg::*;

    localparam int AdjW  = 11;
    localparam int ProdW = 13;
    localparam int ShW   = ProdW - 4;

    logic signed [7:0]      carry_reg, carry_next;
    logic signed [ErrW-1:0] bl_pend_reg, bl_pend_next;
    logic signed [4:0]      b_pend_reg, b_pend_next;

    logic signed [7:0]      carry_eff;
    logic signed [ErrW-1:0] bl_eff;
    logic signed [4:0]      b_eff;
    logic signed [AdjW-1:0] adj;
    logic [PixW-1:0]        adj_sat;
    logic                   q;
    logic signed [ErrW-1:0] err_raw;
    logic signed [ErrW-1:0] floor_ext;
    logic signed [ErrW-1:0] err;
    logic signed [ProdW-1:0] e13, p3, p5, p7;
    logic signed [ShW-1:0]  s1, s3, s5, s7;

    // Frame start clears the running sums before this pixel
    assign carry_eff = ctl.frame ? '0 : carry_reg;
    assign bl_eff    = ctl.frame ? '0 : bl_pend_reg;
    assign b_eff     = ctl.frame ? '0 : b_pend_reg;

    // Add diffused error once and saturate
    always_comb begin
        adj = $signed({3'b000, orig}) + AdjW'(carry_eff) + AdjW'(above);
        if (adj < 0) begin
            adj_sat = '0;
        end else if (adj > AdjW'(255)) begin
            adj_sat = 8'hFF;
        end else begin
            adj_sat = adj[PixW-1:0];
        end
    end

    // Quantize and floor the error
    assign q         = (adj_sat >= ctl.threshold);
    assign err_raw   = $signed({2'b00, adj_sat}) - (q ? ErrW'(255) : ErrW'(0));
    assign floor_ext = ErrW'(ctl.err_floor);
    assign err       = (err_raw < floor_ext) ? floor_ext : err_raw;

    // Weighted shares, floored by arithmetic shift
    assign e13 = ProdW'(err);
    assign p3  = (e13 <<< 1) + e13;
    assign p5  = (e13 <<< 2) + e13;
    assign p7  = (e13 <<< 3) - e13;
    assign s1  = e13[ProdW-1:4];
    assign s3  = p3[ProdW-1:4];
    assign s5  = p5[ProdW-1:4];
    assign s7  = p7[ProdW-1:4];

    assign res.q        = q;
    assign res.left_sum = bl_eff + ErrW'(s3);
    assign res.merged   = ErrW'(b_eff) + ErrW'(s5);

    // Advance carry and pending sums; drop them at row end
    always_comb begin
        carry_next   = carry_reg;
        bl_pend_next = bl_pend_reg;
        b_pend_next  = b_pend_reg;
        if (ctl.en) begin
            if (ctl.last) begin
                carry_next   = '0;
                bl_pend_next = '0;
                b_pend_next  = '0;
            end else begin
                carry_next   = s7[7:0];
                bl_pend_next = res.merged;
                b_pend_next  = s1[4:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg   <= '0;
            bl_pend_reg <= '0;
            b_pend_reg  <= '0;
        end else begin
            carry_reg   <= carry_next;
            bl_pend_reg <= bl_pend_next;
            b_pend_reg  <= b_pend_next;
        end
    end

endmodule

### sv/fsd_out_buf.sv
// Merge lane decisions into one output word and buffer two words.
module fsd_out_buf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [fsd_pkg::NumLanes-1:0]  q_bits,
    output logic                          full,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [fsd_pkg::DataW-1:0]     m_axis_tdata
);
    import fsd_pkg::*;

    logic [DataW-1:0] word;
    logic [DataW-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    // Expand each lane decision to a full byte
    always_comb begin
        for (int i = 0; i < NumLanes; i++) begin
            word[i*PixW +: PixW] = q_bits[i] ? {PixW{1'b1}} : {PixW{1'b0}};
        end
    end

    assign full          = (count_reg == 2'd2);
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = slot_reg[rd_ptr_reg];
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Hold the words
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/floyd_steinberg_rgb_dither_unit.sv
// Top level of the Floyd-Steinberg RGB dither unit.
// Path: s_axis word and line store read are registered into the compute stage, whose lane
// result goes into the output buffer; the per-pixel right carry closes within that stage.
// Throughput: one pixel per cycle, unless a full output buffer stalls the compute stage.
// Reset (aresetn low, synchronous): registers return to 640 / 128 / -30, column and carries
// clear, first-row flag sets; the line store needs no clearing, first rows ignore its read.
module floyd_steinberg_rgb_dither_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fsd_pkg::DataW-1:0]       s_axis_tdata,  // blue_in, green_in, red_in
    input  logic                            s_axis_tuser,  // frame_start
    // Result words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fsd_pkg::DataW-1:0]       m_axis_tdata,  // blue_out, green_out, red_out
    // Register writes
    input  logic                            cfg_we,
    input  logic [fsd_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [fsd_pkg::CfgDataW-1:0]    cfg_wdata
);
    import fsd_pkg::*;

    // Registers
    logic [LineWidthW-1:0]    line_width_reg;
    logic [ThreshW-1:0]       threshold_reg;
    logic signed [FloorW-1:0] err_floor_reg;

    // Column tracking (accept side)
    logic [ColW-1:0]  col_reg, col_next;
    logic             first_row_reg, first_row_next;
    logic [CmpW-1:0]  lw_ext;
    logic [WCntW-1:0] eff_w;
    logic [ColW-1:0]  col_raw, col;
    logic             first, last;
    logic             s_fire;

    // Compute stage
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_frame_reg, s1_last_reg, s1_first_reg;
    logic [ColW-1:0]      s1_col_reg;
    logic [DataW-1:0]     s1_pix_reg;
    logic                 s1_fwd_valid_reg;
    logic [StoreW-1:0]    s1_fwd_data_reg;
    logic                 s1_fire;
    logic                 buf_full;

    // Line store ports and deferred row-end write
    logic              wr_en;
    logic [ColW-1:0]   wr_addr;
    logic [StoreW-1:0] wr_data;
    logic [StoreW-1:0] rd_data;
    logic [StoreW-1:0] above_word;
    logic              left_wr;
    logic              pend_valid_reg, pend_valid_next;
    logic [ColW-1:0]   pend_addr_reg;
    logic [StoreW-1:0] pend_data_reg;
    logic              fwd_valid;
    logic [StoreW-1:0] fwd_data;

    fsd_lane_ctl_t                lane_ctl;
    fsd_lane_res_t [NumLanes-1:0] lane_res;
    logic [StoreW-1:0]            left_word, merged_word;
    logic [NumLanes-1:0]          q_bits;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LineWidthRst;
            threshold_reg  <= ThreshRst;
            err_floor_reg  <= FloorRst;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LINE_WIDTH:  line_width_reg <= cfg_wdata[LineWidthW-1:0];
                REG_THRESHOLD:   threshold_reg  <= cfg_wdata[ThreshW-1:0];
                REG_ERROR_FLOOR: err_floor_reg  <= cfg_wdata[FloorW-1:0];
                default: ;
            endcase
        end
    end

    // Effective row width: zero acts as one, clamp to store depth
    always_comb begin
        lw_ext = CmpW'(line_width_reg);
        if (lw_ext == '0) begin
            eff_w = WCntW'(1);
        end else if (lw_ext > CmpW'(MaxWidth)) begin
            eff_w = WCntW'(MaxWidth);
        end else begin
            eff_w = lw_ext[WCntW-1:0];
        end
    end

    // Resolve column and row position of the arriving pixel
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        col_raw = s_axis_tuser ? '0 : col_reg;
        first   = s_axis_tuser ? 1'b1 : first_row_reg;
        if (WCntW'(col_raw) >= eff_w) begin
            col = ColW'(eff_w - WCntW'(1));
        end else begin
            col = col_raw;
        end
        last = (WCntW'(col) + WCntW'(1) >= eff_w);

        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (s_fire) begin
            if (last) begin
                col_next       = '0;
                first_row_next = 1'b0;
            end else begin
                col_next       = col + ColW'(1);
                first_row_next = first;
            end
        end
    end

    // Lanes: blue, green, red
    assign s1_fire            = s1_valid_reg && !buf_full;
    assign lane_ctl.en        = s1_fire;
    assign lane_ctl.frame     = s1_frame_reg;
    assign lane_ctl.last      = s1_last_reg;
    assign lane_ctl.threshold = threshold_reg;
    assign lane_ctl.err_floor = err_floor_reg;

    always_comb begin
        if (s1_first_reg) begin
            above_word = '0;
        end else if (s1_fwd_valid_reg) begin
            above_word = s1_fwd_data_reg;
        end else begin
            above_word = rd_data;
        end
    end

    for (genvar i = 0; i < NumLanes; i++) begin : g_lane
        fsd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .orig    (s1_pix_reg[i*PixW +: PixW]),
            .above   (above_word[i*ErrW +: ErrW]),
            .res     (lane_res[i])
        );
        assign left_word[i*ErrW +: ErrW]   = lane_res[i].left_sum;
        assign merged_word[i*ErrW +: ErrW] = lane_res[i].merged;
        assign q_bits[i]                   = lane_res[i].q;
    end

    // Store write: below-left sum first, else drain the row-end entry
    assign left_wr = s1_fire && (s1_col_reg != '0);

    always_comb begin
        if (left_wr) begin
            wr_en   = 1'b1;
            wr_addr = s1_col_reg - ColW'(1);
            wr_data = left_word;
        end else begin
            wr_en   = pend_valid_reg;
            wr_addr = pend_addr_reg;
            wr_data = pend_data_reg;
        end
        if (s1_fire && s1_last_reg) begin
            pend_valid_next = 1'b1;
        end else if (!left_wr) begin
            pend_valid_next = 1'b0;
        end else begin
            pend_valid_next = pend_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_last_reg) begin
            pend_addr_reg <= s1_col_reg;
            pend_data_reg <= merged_word;
        end
    end

    // Forward writes the memory read will miss, newest first
    always_comb begin
        fwd_valid = 1'b0;
        fwd_data  = pend_data_reg;
        if (s1_fire && s1_last_reg && (s1_col_reg == col)) begin
            fwd_valid = 1'b1;
            fwd_data  = merged_word;
        end else if (left_wr && (s1_col_reg - ColW'(1) == col)) begin
            fwd_valid = 1'b1;
            fwd_data  = left_word;
        end else if (pend_valid_reg && (pend_addr_reg == col)) begin
            fwd_valid = 1'b1;
            fwd_data  = pend_data_reg;
        end
    end

    fsd_line_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_fire),
        .rd_addr (col),
        .rd_data (rd_data)
    );

    // Advance the compute stage
    always_comb begin
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_frame_reg     <= s_axis_tuser;
            s1_last_reg      <= last;
            s1_first_reg     <= first;
            s1_col_reg       <= col;
            s1_pix_reg       <= s_axis_tdata;
            s1_fwd_valid_reg <= fwd_valid;
            s1_fwd_data_reg  <= fwd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            first_row_reg  <= 1'b1;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            first_row_reg  <= first_row_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    fsd_out_buf u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (s1_fire),
        .q_bits        (q_bits),
        .full          (buf_full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A below-left write never meets an undrained row-end entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        left_wr |-> !pend_valid_reg)
        else $error("row-end entry still pending during below-left write");

    // Every output channel is black or white
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tdata[7:0] == 8'h00) || (m_axis_tdata[7:0] == 8'hFF))
                       && ((m_axis_tdata[15:8] == 8'h00) || (m_axis_tdata[15:8] == 8'hFF))
                       && ((m_axis_tdata[23:16] == 8'h00) || (m_axis_tdata[23:16] == 8'hFF)))
        else $error("output channel not 0 or 255");

    // A row end returns the column to zero and leaves the first row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && last) |=> (col_reg == '0) && !first_row_reg)
        else $error("row end did not wrap the column");

    // An accepted pixel always reaches the compute stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> s1_valid_reg)
        else $error("accepted pixel lost before compute");

endmodule
